>>> sv/oets_pkg.sv
// ----------------------------------------------------------------------------
// Odd-even transposition sort package
// Request payload types, cell control bundle and default sizes shared by the
// sorter top level and its cells.
// ----------------------------------------------------------------------------
package oets_pkg;

    localparam int VALUE_W   = 32;
    localparam int DEPTH_DEF = 64;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   last;
    } t_in;

    typedef struct packed {
        t_value sorted_value;
        logic   final_res;
        logic   overflow;
    } t_out;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;       // an element is being written at the fill position
        logic sort;       // an exchange phase runs this cycle
        logic odd_phase;  // 0: pairs (0,1),(2,3)...  1: pairs (1,2),(3,4)...
        logic shift;      // every cell takes its right neighbour's value
    } t_cell_ctl;

endpackage

>>> sv/oets_cell.sv
// ----------------------------------------------------------------------------
// Odd-even transposition sort cell
// Holds one list element; loads, compare-exchanges with a neighbour, or
// shifts towards the output end of the chain.
// ----------------------------------------------------------------------------
module oets_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                i_clk,
    input  oets_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    input  oets_pkg::t_value    i_load_value,
    input  oets_pkg::t_value    i_left_val,
    input  logic                i_left_gt,
    input  oets_pkg::t_value    i_right_val,
    output oets_pkg::t_value    o_val,
    output logic                o_gt
);

    localparam logic [CW-1:0] K_IDX   = CW'(IDX);
    localparam logic [CW-1:0] K_NEXT  = CW'(IDX + 1);
    localparam logic          K_PAR   = 1'(IDX % 2);
    localparam logic          K_IS_LO = (IDX > 0);

    oets_pkg::t_value r_val;
    oets_pkg::t_value n_val;
    logic             w_low;
    logic             w_high;

    // This cell greater than its right neighbour: shared with that neighbour.
    assign o_gt  = (r_val > i_right_val);
    assign o_val = r_val;

    // Lower member of a pair takes the minimum, upper member the maximum.
    assign w_low  = i_ctl.sort && (i_ctl.odd_phase == K_PAR) && (K_NEXT < i_count) && o_gt;
    assign w_high = i_ctl.sort && K_IS_LO && (i_ctl.odd_phase != K_PAR)
                    && (K_IDX < i_count) && i_left_gt;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load && (i_count == K_IDX)) begin
            n_val = i_load_value;
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (w_low) begin
            n_val = i_right_val;
        end else if (w_high) begin
            n_val = i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> sv/odd_even_transposition_sort_top.sv
// ----------------------------------------------------------------------------
// Odd-even transposition sorter, top level
// Collects a list of signed Q16.16 values, sorts it in a chain of cells and
// returns it in ascending order.
// ----------------------------------------------------------------------------
// A list of n elements is written one request per cycle into a row of DEPTH
// cells, up to and including the request marked last. The sorter then runs n
// compare-exchange phases, one per cycle, alternating between even and odd
// neighbour pairs, and finally shifts the n sorted values out of cell 0, one
// result request per cycle while the consumer is ready, the largest marked
// final. Input is not accepted while a list is being sorted or drained.
// Elements arriving after DEPTH are stored are dropped; the list still ends
// at its last mark and every result of that list carries the overflow flag.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_top #(
    parameter int DEPTH = oets_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  oets_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output oets_pkg::t_out o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] K_DEPTH = CW'(DEPTH);
    localparam logic [CW-1:0] K_ONE   = CW'(1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;   // elements held in the chain
    logic [CW-1:0]       r_pass;    // exchange phase index
    logic [CW-1:0]       r_left;    // results still to be delivered
    logic                r_ovf;     // an element of this list was dropped

    logic                w_in_acc;
    logic                w_out_acc;
    oets_pkg::t_cell_ctl w_ctl;
    oets_pkg::t_value    w_val [DEPTH];
    logic                w_gt  [DEPTH];

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_DRAIN);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    // The head of the chain is the result register.
    assign o_out_data.sorted_value = w_val[0];
    assign o_out_data.final_res    = (r_left == K_ONE);
    assign o_out_data.overflow     = r_ovf;

    assign w_ctl.load      = w_in_acc && (r_count < K_DEPTH);
    assign w_ctl.sort      = (r_state == ST_SORT);
    assign w_ctl.odd_phase = r_pass[0];
    assign w_ctl.shift     = w_out_acc;

    // Row of cells: each sees its neighbours' values and the left one's
    // compare result, so every pair makes one decision.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        oets_pkg::t_value w_left_val;
        oets_pkg::t_value w_right_val;
        logic             w_left_gt;

        if (g == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_mid
            assign w_left_val = w_val[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_body
            assign w_right_val = w_val[g+1];
        end

        oets_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_load_value (i_in_data.value),
            .i_left_val   (w_left_val),
            .i_left_gt    (w_left_gt),
            .i_right_val  (w_right_val),
            .o_val        (w_val[g]),
            .o_gt         (w_gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_pass  <= '0;
            r_left  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count < K_DEPTH) begin
                            r_count <= r_count + K_ONE;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_data.last) begin
                            r_pass  <= '0;
                            r_state <= ST_SORT;
                        end
                    end
                end
                ST_SORT: begin
                    // n phases, numbered 0 to n-1, sort n elements.
                    if (r_pass == r_count - K_ONE) begin
                        r_left  <= r_count;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_pass <= r_pass + K_ONE;
                    end
                end
                ST_DRAIN: begin
                    if (w_out_acc) begin
                        r_left <= r_left - K_ONE;
                        if (r_left == K_ONE) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule
